// ===== rtl/arpc_pkg.sv =====
// shared types, codes and constants of the arp cache
package arpc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [15:0] MIN_ARP_LEN = 16'd28;
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] OP_REQUEST  = 16'h0001;
  localparam logic [31:0] IP_BCAST    = 32'hFFFF_FFFF;
  localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
  localparam logic [4:0]  COUNT_MAX   = 5'd31;

  // item kinds carried on s_axis_tuser
  localparam logic ACT_RX      = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_DROPPED = 3'd0,
    ST_LEARNED = 3'd1,
    ST_REPLY   = 3'd2,
    ST_HIT     = 3'd3,
    ST_BCAST   = 3'd4,
    ST_MISS    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_OWN_IP   = 2'd0,
    CFG_OWN_MAC  = 2'd1,
    CFG_NET_MASK = 2'd2,
    CFG_GATEWAY  = 2'd3
  } cfg_reg_e;

  // search token handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic [31:0] key;
    logic        hit;
    idx_t        hit_idx;
    logic [47:0] hit_mac;
    logic        free;
    idx_t        free_idx;
    cnt_t        cnt;
  } sweep_t;

  // table write broadcast to all cells
  typedef struct packed {
    logic        en;
    idx_t        idx;
    logic        set_vld;
    logic [31:0] ip;
    logic [47:0] mac;
  } wr_t;

endpackage

// ===== rtl/arp_cache_learn_resolve.sv =====
// arp cache top level: item control, row of table cells, result register
//
//  channel  | direction | tdata (low bit up)                       | tuser
//  s_axis   | in        | pkt_len hw_type proto_type opcode        | action
//           |           | sender_ip sender_mac dst_ip              |
//  m_axis   | out       | mac_out ip_out valid_count (zero pad)    | status
//  cfg      | in        | cfg_we_i, cfg_idx_i, cfg_data_i          | -
//
// one item at a time: the search token walks the cell row one cell per cycle.
// the table is learned at the end of the walk, one write to one cell.
// a new item is taken while the last result still waits on m_axis.
// reset clears all valid bits at once; no clearing pass.
module arp_cache_learn_resolve import arpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pkt_len, hw_type, proto_type, opcode, sender_ip, sender_mac, dst_ip
  input  logic [175:0] s_axis_tdata,
  input  logic         s_axis_tuser,  // action
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mac_out, ip_out, valid_count, zero pad
  output logic [87:0]  m_axis_tdata,
  output logic [2:0]   m_axis_tuser,  // status
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [47:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_e;

  state_e      state_q;
  logic [31:0] own_ip_q, net_mask_q, gateway_q;

  logic        start_q;
  logic        action_q, ok_q, reply_q, bcast_q;
  logic [31:0] key_q;
  logic [47:0] smac_q;

  logic [15:0] in_pkt_len, in_hw_type, in_proto, in_opcode;
  logic [31:0] in_sender_ip, in_dst_ip, in_hop;
  logic [47:0] in_sender_mac;
  logic        accept;

  sweep_t      tok [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] vld_vec;
  wr_t         wr;

  status_e     res_status_d, res_status_q;
  logic [47:0] res_mac_d, res_mac_q;
  logic [31:0] res_ip_d, res_ip_q;
  logic [4:0]  res_cnt_d, res_cnt_q;
  cnt_t        cnt_new;
  logic        learn;

  logic        out_vld_q;
  status_e     out_status_q;
  logic [47:0] out_mac_q;
  logic [31:0] out_ip_q;
  logic [4:0]  out_cnt_q;
  logic        out_load;

  assign in_pkt_len    = s_axis_tdata[15:0];
  assign in_hw_type    = s_axis_tdata[31:16];
  assign in_proto      = s_axis_tdata[47:32];
  assign in_opcode     = s_axis_tdata[63:48];
  assign in_sender_ip  = s_axis_tdata[95:64];
  assign in_sender_mac = s_axis_tdata[143:96];
  assign in_dst_ip     = s_axis_tdata[175:144];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // next hop: gateway when off-subnet and a gateway is set
  assign in_hop = (((own_ip_q & net_mask_q) != (in_dst_ip & net_mask_q)) &&
                   (gateway_q != 32'd0)) ? gateway_q : in_dst_ip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q   <= '0;
      net_mask_q <= '0;
      gateway_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_OWN_IP:   own_ip_q   <= cfg_data_i[31:0];
        CFG_NET_MASK: net_mask_q <= cfg_data_i[31:0];
        CFG_GATEWAY:  gateway_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= s_axis_tuser;
      ok_q     <= (in_pkt_len >= MIN_ARP_LEN) && (in_hw_type == HW_ETHERNET) &&
                  (in_proto == PROTO_IPV4);
      reply_q  <= (in_opcode == OP_REQUEST) && (in_dst_ip == own_ip_q);
      bcast_q  <= (in_dst_ip == IP_BCAST);
      key_q    <= (s_axis_tuser == ACT_RESOLVE) ? in_hop : in_sender_ip;
      smac_q   <= in_sender_mac;
    end
  end

  // token entering the first cell
  always_comb begin
    tok[0]     = '0;
    tok[0].vld = start_q;
    tok[0].key = key_q;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    arpc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (idx_t'(i)),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1]),
      .wr_i   (wr),
      .valid_o(vld_vec[i])
    );
  end

  // learn when the token of a well-formed rx item leaves the last cell
  assign learn = tok[TABLE_ENTRIES].vld && (action_q == ACT_RX) && ok_q;

  always_comb begin
    wr     = '0;
    wr.en  = learn;
    wr.ip  = key_q;
    wr.mac = smac_q;
    if (tok[TABLE_ENTRIES].hit) begin
      wr.idx = tok[TABLE_ENTRIES].hit_idx;
    end else if (tok[TABLE_ENTRIES].free) begin
      wr.idx     = tok[TABLE_ENTRIES].free_idx;
      wr.set_vld = learn;
    end else begin
      wr.idx = '0;
    end
  end

  assign cnt_new   = tok[TABLE_ENTRIES].cnt + cnt_t'(wr.set_vld);
  assign res_cnt_d = (32'(cnt_new) > 32'(COUNT_MAX)) ? COUNT_MAX : 5'(cnt_new);

  always_comb begin
    res_status_d = ST_DROPPED;
    res_mac_d    = '0;
    res_ip_d     = '0;
    if (action_q == ACT_RX) begin
      if (ok_q) begin
        if (reply_q) begin
          res_status_d = ST_REPLY;
          res_mac_d    = smac_q;
          res_ip_d     = key_q;
        end else begin
          res_status_d = ST_LEARNED;
        end
      end
    end else if (bcast_q) begin
      res_status_d = ST_BCAST;
      res_mac_d    = MAC_BCAST;
      res_ip_d     = IP_BCAST;
    end else if (tok[TABLE_ENTRIES].hit) begin
      res_status_d = ST_HIT;
      res_mac_d    = tok[TABLE_ENTRIES].hit_mac;
      res_ip_d     = key_q;
    end else begin
      res_status_d = ST_MISS;
      res_ip_d     = key_q;
    end
  end

  assign out_load = (state_q == S_FINISH) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      start_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      start_q <= accept;
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_SWEEP;
        end
        S_SWEEP: begin
          if (tok[TABLE_ENTRIES].vld) state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok[TABLE_ENTRIES].vld) begin
      res_status_q <= res_status_d;
      res_mac_q    <= res_mac_d;
      res_ip_q     <= res_ip_d;
      res_cnt_q    <= res_cnt_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_mac_q    <= res_mac_q;
      out_ip_q     <= res_ip_q;
      out_cnt_q    <= res_cnt_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_cnt_q, out_ip_q, out_mac_q};

  // the token only leaves the row while an item is being searched
  a_tok_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[TABLE_ENTRIES].vld |-> state_q == S_SWEEP)
    else $error("search token left the cell row outside a sweep");

  // table writes happen only at the end of a sweep
  a_wr_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == S_SWEEP) && tok[TABLE_ENTRIES].vld)
    else $error("table write outside the end of a sweep");

  // filling a free entry adds exactly one valid bit
  a_fill_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.en && wr.set_vld) |=>
      $countones(vld_vec) == $countones($past(vld_vec)) + 1)
    else $error("free entry fill did not add one valid entry");

endmodule

// ===== rtl/arpc_cell.sv =====
// one table entry: holds valid, ip and mac, and forwards the search token
module arpc_cell import arpc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  idx_t   idx_i,
  input  sweep_t tok_i,
  output sweep_t tok_o,
  input  wr_t    wr_i,
  output logic   valid_o
);

  logic        valid_q;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic        tok_vld_q;
  sweep_t      tok_d, tok_q;
  logic        match;
  logic        wr_sel;

  assign match  = valid_q && (ip_q == tok_i.key);
  assign wr_sel = wr_i.en && (wr_i.idx == idx_i);

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && match) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = idx_i;
      tok_d.hit_mac = mac_q;
    end
    if (!tok_i.free && !valid_q) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = idx_i;
    end
    tok_d.cnt = tok_i.cnt + cnt_t'(valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.vld;
      if (wr_sel && wr_i.set_vld) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_sel) begin
      ip_q  <= wr_i.ip;
      mac_q <= wr_i.mac;
    end
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

  assign valid_o = valid_q;

endmodule
